/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the semaphore table.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every edge outside reset.
`define STU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define STU_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hw/rtl/stu_pkg.sv */
// ----------------------------------------------------------------------------
// stu_pkg
// Types, codes and sizes shared by the semaphore table cells and top level.
// ----------------------------------------------------------------------------
package stu_pkg;

    // Sizes
    localparam int NUM_SLOTS_DEF = 16;
    localparam int HANDLE_W      = 4;
    localparam int HANDLE_SPAN   = 1 << HANDLE_W;
    localparam int ID_W          = 8;
    localparam int CNT_W         = 8;
    localparam int TASK_W        = 8;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 3;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_LOOKUP  = 3'd1,
        OP_ACQUIRE = 3'd2,
        OP_RELEASE = 3'd3,
        OP_UNLOCK  = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_UNAVAIL  = 3'd4,
        ST_ATMAX    = 3'd5,
        ST_NOTOWNER = 3'd6
    } t_status;

    // Request token that walks down the row of cells
    typedef struct packed {
        logic                valid;
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     sem_id;
        logic [HANDLE_W-1:0] handle;
        logic [TASK_W-1:0]   task_id;
        logic                found;      // an active cell matched the id
        logic                free_found; // a free cell was seen
        logic [HANDLE_W-1:0] free_idx;   // lowest free cell
        t_status             status;
        logic [HANDLE_W-1:0] handle_out;
        logic [CNT_W-1:0]    count_out;
    } t_pkt;

    // Slot fill broadcast for a successful create
    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] idx;
        logic [ID_W-1:0]     ident;
        logic [CNT_W-1:0]    value;
    } t_wr;

endpackage

/* hw/rtl/semaphore_table_unit.sv */
// ----------------------------------------------------------------------------
// semaphore_table_unit
// Table of counting semaphores built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an operation on i_op and its operands, then raise start while busy
//   is low; the operation transfers at that edge and busy rises.
//   A request token enters the first cell and moves one cell per cycle; each
//   cell checks the id or handle against its own slot and updates itself.
//   Create writes the chosen free slot once the token has left the last cell,
//   after the duplicate check over all slots is complete.
//   The result appears on o_status, o_handle_out and o_count_out for exactly
//   one cycle with o_done high; o_done is registered from the token leaving
//   the last of USED = min(NUM_SLOTS, 16) cells. busy drops in the cycle
//   o_done is shown, so a new operation can be accepted then; the walk through
//   the cell row must end before the next operation is taken.
//   The receiver must take the result in that cycle; it cannot stall it.
//   Reset empties all slots and drops any operation in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module semaphore_table_unit import stu_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_sem_id,
    input  logic [CNT_W-1:0]    i_initial_value,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [TASK_W-1:0]   i_task_id,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [HANDLE_W-1:0] o_handle_out,
    output logic [CNT_W-1:0]    o_count_out
);

    localparam int USED = (NUM_SLOTS < HANDLE_SPAN) ? NUM_SLOTS : HANDLE_SPAN;

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_init;
    t_pkt                r_inj, n_inj;
    logic                r_done;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_hout, n_hout;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_wr                 w_wr;
    t_pkt                w_pkt [USED+1];
    logic [USED:0]       w_vld;
    logic                accept;
    t_pkt                last;

    assign accept = start && !r_busy;
    assign last   = w_pkt[USED];

    // Build the request token
    always_comb begin
        n_inj = '0;
        if (accept) begin
            n_inj.valid   = 1'b1;
            n_inj.op      = i_op;
            n_inj.sem_id  = i_sem_id;
            n_inj.handle  = i_handle;
            n_inj.task_id = i_task_id;
            n_inj.status  = ST_NOTFOUND;
        end
    end

    assign w_pkt[0] = r_inj;

    // Row of slot cells
    for (genvar g = 0; g < USED; g++) begin : g_cell
        stu_cell #(
            .CELL_IDX(HANDLE_W'(g))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_pkt  (w_pkt[g]),
            .i_wr   (w_wr),
            .o_pkt  (w_pkt[g+1])
        );
    end

    for (genvar g = 0; g <= USED; g++) begin : g_vld
        assign w_vld[g] = w_pkt[g].valid;
    end

    // Finish the token: settle the result and busy, and fill the chosen slot for create
    always_comb begin
        w_wr     = '0;
        n_status = t_status'(last.status);
        n_hout   = last.handle_out;
        n_cnt    = last.count_out;
        n_busy   = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end
        if (last.valid) begin
            n_busy = 1'b0;
            if (last.op == OP_CREATE) begin
                n_hout = '0;
                n_cnt  = '0;
                if (last.found) begin
                    n_status = ST_DUP;
                end else if (!last.free_found) begin
                    n_status = ST_FULL;
                end else begin
                    n_status  = ST_OK;
                    n_hout    = last.free_idx;
                    n_cnt     = r_init;
                    w_wr.en   = 1'b1;
                    w_wr.idx  = last.free_idx;
                    w_wr.ident = last.sem_id;
                    w_wr.value = r_init;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_inj  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_inj  <= n_inj;
            r_done <= last.valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_init <= i_initial_value;
        end
        r_status <= n_status;
        r_hout   <= n_hout;
        r_cnt    <= n_cnt;
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_handle_out = r_hout;
    assign o_count_out  = r_cnt;

    // Checks
    `STU_ASSERT(a_latency, i_clk, i_rst_n, accept |-> ##(USED+2) o_done, "result latency wrong")
    `STU_ASSERT(a_one_token, i_clk, i_rst_n, $onehot0(w_vld), "more than one token in flight")
    `STU_ASSERT(a_busy_token, i_clk, i_rst_n, (w_vld != '0) |-> r_busy, "token while idle")
    `STU_NEVER(a_done_pair, i_clk, i_rst_n, o_done && $past(o_done), "result strobe too long")

endmodule

/* hw/rtl/stu_cell.sv */
// ----------------------------------------------------------------------------
// stu_cell
// One semaphore slot: holds its state, serves the request token as it passes
// and hands the token to the next cell through its output register.
// ----------------------------------------------------------------------------
module stu_cell import stu_pkg::*; #(
    parameter logic [HANDLE_W-1:0] CELL_IDX = '0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_pkt i_pkt,
    input  t_wr  i_wr,
    output t_pkt o_pkt
);

    logic              r_in_use, n_in_use;
    logic [ID_W-1:0]   r_ident, n_ident;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_limit, n_limit;
    logic              r_own_valid, n_own_valid;
    logic [TASK_W-1:0] r_own_task, n_own_task;
    t_pkt              r_pkt, n_pkt;

    logic hit_id;
    logic hit_h;

    assign hit_id = r_in_use && (r_ident == i_pkt.sem_id);
    assign hit_h  = r_in_use && (i_pkt.handle == CELL_IDX);

    // Serve the token and update the slot
    always_comb begin
        n_in_use    = r_in_use;
        n_ident     = r_ident;
        n_count     = r_count;
        n_limit     = r_limit;
        n_own_valid = r_own_valid;
        n_own_task  = r_own_task;
        n_pkt       = i_pkt;

        if (i_wr.en && (i_wr.idx == CELL_IDX)) begin
            n_in_use    = 1'b1;
            n_ident     = i_wr.ident;
            n_count     = i_wr.value;
            n_limit     = i_wr.value;
            n_own_valid = 1'b0;
        end else if (i_pkt.valid) begin
            unique case (i_pkt.op)
                OP_CREATE: begin
                    if (hit_id) begin
                        n_pkt.found = 1'b1;
                    end
                    if (!r_in_use && !i_pkt.free_found) begin
                        n_pkt.free_found = 1'b1;
                        n_pkt.free_idx   = CELL_IDX;
                    end
                end
                OP_LOOKUP: begin
                    if (hit_id && !i_pkt.found) begin
                        n_pkt.found      = 1'b1;
                        n_pkt.status     = ST_OK;
                        n_pkt.handle_out = CELL_IDX;
                        n_pkt.count_out  = r_count;
                    end
                end
                OP_ACQUIRE: begin
                    if (hit_h) begin
                        if (r_count != '0) begin
                            n_count      = r_count - CNT_W'(1);
                            n_own_valid  = 1'b1;
                            n_own_task   = i_pkt.task_id;
                            n_pkt.status = ST_OK;
                        end else begin
                            n_pkt.status = ST_UNAVAIL;
                        end
                        n_pkt.count_out = n_count;
                    end
                end
                OP_RELEASE: begin
                    if (hit_h) begin
                        if (r_count < r_limit) begin
                            n_count      = r_count + CNT_W'(1);
                            n_own_valid  = 1'b0;
                            n_pkt.status = ST_OK;
                        end else begin
                            n_pkt.status = ST_ATMAX;
                        end
                        n_pkt.count_out = n_count;
                    end
                end
                OP_UNLOCK: begin
                    if (hit_h) begin
                        if (!(r_own_valid && (r_own_task == i_pkt.task_id))) begin
                            n_pkt.status = ST_NOTOWNER;
                        end else if (r_count < r_limit) begin
                            n_count      = r_count + CNT_W'(1);
                            n_own_valid  = 1'b0;
                            n_pkt.status = ST_OK;
                        end else begin
                            n_pkt.status = ST_ATMAX;
                        end
                        n_pkt.count_out = n_count;
                    end
                end
                default: begin
                    n_pkt = i_pkt;
                end
            endcase
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= 1'b0;
            r_count     <= '0;
            r_limit     <= '0;
            r_own_valid <= 1'b0;
            r_pkt       <= '0;
        end else begin
            r_in_use    <= n_in_use;
            r_count     <= n_count;
            r_limit     <= n_limit;
            r_own_valid <= n_own_valid;
            r_pkt       <= n_pkt;
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        r_ident    <= n_ident;
        r_own_task <= n_own_task;
    end

    assign o_pkt = r_pkt;

endmodule

/* dv/semaphore_table_checker.sv */
// ----------------------------------------------------------------------------
// semaphore_table_checker
// Watches the command and result ports of the semaphore table. Keeps its own
// copy of the slot table, predicts the result of every accepted transfer and
// compares each strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module semaphore_table_checker import stu_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [ID_W-1:0]     i_sem_id,
    input  logic [CNT_W-1:0]    i_initial_value,
    input  logic [HANDLE_W-1:0] i_handle,
    input  logic [TASK_W-1:0]   i_task_id,
    input  logic                i_done,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [HANDLE_W-1:0] i_handle_out,
    input  logic [CNT_W-1:0]    i_count_out,
    output int                  o_mismatches,
    output int                  o_outstanding
);

    // Only the slots a 4-bit handle can reach are ever used
    localparam int USED_SLOTS = (NUM_SLOTS < HANDLE_SPAN) ? NUM_SLOTS : HANDLE_SPAN;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] handle;
        logic [CNT_W-1:0]    count;
    } t_sem_result;

    logic                slot_active [HANDLE_SPAN];
    logic [ID_W-1:0]     slot_ident  [HANDLE_SPAN];
    logic [CNT_W-1:0]    slot_count  [HANDLE_SPAN];
    logic [CNT_W-1:0]    slot_limit  [HANDLE_SPAN];
    logic                owner_held  [HANDLE_SPAN];
    logic [TASK_W-1:0]   owner_num   [HANDLE_SPAN];
    t_sem_result         awaited_results [$];
    int                  mismatch_count = 0;

    // Return the active slot carrying the id, or -1
    function automatic int find_active_id(logic [ID_W-1:0] id);
        for (int i = 0; i < USED_SLOTS; i++) begin
            if (slot_active[i] && slot_ident[i] == id) return i;
        end
        return -1;
    endfunction

    // Give one unit back unless the count is already at its maximum
    function automatic t_status give_back(int slot);
        if (slot_count[slot] < slot_limit[slot]) begin
            slot_count[slot] = slot_count[slot] + 1'b1;
            owner_held[slot] = 1'b0;
            return ST_OK;
        end
        return ST_ATMAX;
    endfunction

    // Apply one operation to the shadow table and return its result
    function automatic t_sem_result apply_semaphore_op(
        logic [OP_W-1:0]     op,
        logic [ID_W-1:0]     id,
        logic [CNT_W-1:0]    init,
        logic [HANDLE_W-1:0] hnd,
        logic [TASK_W-1:0]   tsk
    );
        t_sem_result res;
        int          slot;
        res = '{status: ST_NOTFOUND, handle: '0, count: '0};
        case (op)
            OP_CREATE: begin
                if (find_active_id(id) >= 0) begin
                    res.status = ST_DUP;
                end else begin
                    // pick the lowest free slot
                    slot = -1;
                    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
                        if (!slot_active[i]) slot = i;
                    end
                    if (slot < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        slot_active[slot] = 1'b1;
                        slot_ident[slot]  = id;
                        slot_count[slot]  = init;
                        slot_limit[slot]  = init;
                        owner_held[slot]  = 1'b0;
                        res = '{status: ST_OK, handle: HANDLE_W'(slot), count: init};
                    end
                end
            end
            OP_LOOKUP: begin
                slot = find_active_id(id);
                if (slot >= 0) begin
                    res = '{status: ST_OK, handle: HANDLE_W'(slot), count: slot_count[slot]};
                end
            end
            OP_ACQUIRE, OP_RELEASE, OP_UNLOCK: begin
                if (int'(hnd) < USED_SLOTS && slot_active[hnd]) begin
                    if (op == OP_ACQUIRE) begin
                        if (slot_count[hnd] != '0) begin
                            slot_count[hnd] = slot_count[hnd] - 1'b1;
                            owner_held[hnd] = 1'b1;
                            owner_num[hnd]  = tsk;
                            res.status      = ST_OK;
                        end else begin
                            res.status = ST_UNAVAIL;
                        end
                    end else if (op == OP_RELEASE) begin
                        res.status = give_back(hnd);
                    end else if (owner_held[hnd] && owner_num[hnd] == tsk) begin
                        res.status = give_back(hnd);
                    end else begin
                        res.status = ST_NOTOWNER;
                    end
                    res.count = slot_count[hnd];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(string label, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Retire results first, then record the transfer taken at the same edge
    always @(posedge i_clk) begin : watch
        t_sem_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < HANDLE_SPAN; i++) begin
                slot_active[i] = 1'b0;
                slot_count[i]  = '0;
                slot_limit[i]  = '0;
                owner_held[i]  = 1'b0;
            end
            awaited_results.delete();
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result with no transfer outstanding, expected none, actual %0d/%0d/%0d",
                             $time, i_status, i_handle_out, i_count_out);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", CNT_W'(want.status), CNT_W'(i_status));
                    check_field("handle_out", CNT_W'(want.handle), CNT_W'(i_handle_out));
                    check_field("count_out", want.count, i_count_out);
                end
            end
            if (i_start && !i_busy) begin
                awaited_results.push_back(apply_semaphore_op(i_op, i_sem_id, i_initial_value,
                                                             i_handle, i_task_id));
            end
        end
        o_outstanding <= awaited_results.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the semaphore table with a directed sequence and then random
// operations under several sender idle patterns; the checker beside the
// block predicts and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import stu_pkg::*; ();

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // Codes the block does not define; they must come back as not found
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                start           = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op            = '0;
    logic [ID_W-1:0]     i_sem_id        = '0;
    logic [CNT_W-1:0]    i_initial_value = '0;
    logic [HANDLE_W-1:0] i_handle        = '0;
    logic [TASK_W-1:0]   i_task_id       = '0;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [CNT_W-1:0]    o_count_out;
    int                  mismatches;
    int                  outstanding;
    int                  idle_pct        = 0;
    int                  cycle_count     = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    semaphore_table_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_sem_id        (i_sem_id),
        .i_initial_value (i_initial_value),
        .i_handle        (i_handle),
        .i_task_id       (i_task_id),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_handle_out    (o_handle_out),
        .o_count_out     (o_count_out)
    );

    semaphore_table_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_op            (i_op),
        .i_sem_id        (i_sem_id),
        .i_initial_value (i_initial_value),
        .i_handle        (i_handle),
        .i_task_id       (i_task_id),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_handle_out    (o_handle_out),
        .i_count_out     (o_count_out),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL semaphore_table_unit");
            $finish;
        end
    end

    // Present one operation, hold it until the transfer, then idle at random
    task automatic issue(
        logic [OP_W-1:0]     op,
        logic [ID_W-1:0]     id,
        logic [CNT_W-1:0]    init,
        logic [HANDLE_W-1:0] hnd,
        logic [TASK_W-1:0]   tsk
    );
        start           <= 1'b1;
        i_op            <= op;
        i_sem_id        <= id;
        i_initial_value <= init;
        i_handle        <= hnd;
        i_task_id       <= tsk;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Random operation; ids and task numbers cluster so lookups and owners hit
    task automatic random_item();
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  init;
        logic [TASK_W-1:0] tsk;
        pick = $urandom_range(99);
        if (pick < 10)      op = OP_CREATE;
        else if (pick < 25) op = OP_LOOKUP;
        else if (pick < 55) op = OP_ACQUIRE;
        else if (pick < 75) op = OP_RELEASE;
        else if (pick < 95) op = OP_UNLOCK;
        else                op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        if ($urandom_range(3) != 0) begin
            id = {($urandom_range(1) != 0) ? 4'hF : 4'h0, 4'($urandom_range(15))};
        end else begin
            id = ID_W'($urandom_range(255));
        end
        case ($urandom_range(4))
            0:       init = 8'd0;
            1:       init = 8'd1;
            2:       init = 8'd255;
            3:       init = CNT_W'($urandom_range(2, 6));
            default: init = CNT_W'($urandom_range(255));
        endcase
        if ($urandom_range(4) == 0) tsk = TASK_W'($urandom_range(255));
        else                        tsk = TASK_W'($urandom_range(3));
        issue(op, id, init, 4'($urandom_range(15)), tsk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table: every lookup and handle access misses
        issue(OP_LOOKUP,  8'h00, 8'h00, 4'h0, 8'h00);
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h0, 8'h00);
        issue(OP_RELEASE, 8'h00, 8'h00, 4'hF, 8'hFF);
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h7, 8'h01);
        // Creates at the extremes, a duplicate, and a mutex
        issue(OP_CREATE,  8'h00, 8'h00, 4'h0, 8'h00);
        issue(OP_CREATE,  8'hFF, 8'hFF, 4'hF, 8'hFF);
        issue(OP_CREATE,  8'h00, 8'h05, 4'h0, 8'h00);
        issue(OP_CREATE,  8'h5A, 8'h01, 4'h0, 8'h00);
        issue(OP_LOOKUP,  8'hFF, 8'h00, 4'h0, 8'h00);
        // Empty semaphore and semaphores at their maximum
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h0, 8'h10);
        issue(OP_RELEASE, 8'h00, 8'h00, 4'h0, 8'h10);
        issue(OP_RELEASE, 8'h00, 8'h00, 4'h1, 8'h10);
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h1, 8'hFF);
        // Mutex ownership: no owner, wrong owner, right owner, owner cleared
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h2, 8'h03);
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h2, 8'h03);
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h2, 8'h04);
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h2, 8'h04);
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h2, 8'h03);
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h2, 8'h03);
        issue(OP_ACQUIRE, 8'h00, 8'h00, 4'h2, 8'hA5);
        issue(OP_RELEASE, 8'h00, 8'h00, 4'h2, 8'h00);
        issue(OP_UNLOCK,  8'h00, 8'h00, 4'h2, 8'hA5);
        // Undefined codes on an active slot
        issue(OP_SPARE_LO, 8'hFF, 8'h01, 4'h1, 8'h00);
        issue(OP_SPARE_HI, 8'h5A, 8'h01, 4'h1, 8'h00);
        issue(OP_LOOKUP,  8'h5A, 8'h00, 4'h0, 8'h00);

        // Random traffic under changing sender idle patterns
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 82 : (phase == 2) ? 29 : 0;
            repeat (RANDOM_ITEMS / 4) random_item();
        end
        start <= 1'b0;

        // Drain outstanding results
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS semaphore_table_unit");
        end else begin
            $display("FAIL semaphore_table_unit");
        end
        $finish;
    end

endmodule
